### hdl/uft_pkg.sv
// Shared types and constants for the UDP flow table.
`default_nettype none
package uft_pkg;
  localparam int BUCKETS = 16;
  localparam int WAYS = 4;
  localparam int SAVE_SLOTS = 8;
  localparam int BKT_W = 4;
  localparam int WAY_W = 2;
  localparam int SLOT_W = 3;
  localparam int CNT_W = 4;
  localparam int ENTRIES = BUCKETS * WAYS;
  localparam int ENT_W = BKT_W + WAY_W;
  localparam int QUEUE_DEPTH = 2;
  localparam logic [15:0] HDR_BYTES = 16'd28;
  localparam logic [15:0] TIMEOUT_RESET = 16'd15;
  localparam logic [CNT_W-1:0] SLOTS_FULL = CNT_W'(SAVE_SLOTS);

  typedef enum logic [2:0] {
    EV_IGNORED = 3'd0,
    EV_NEW = 3'd1,
    EV_SLOT = 3'd2,
    EV_FLOW_FULL = 3'd3,
    EV_BKT_FULL = 3'd4,
    EV_EXPIRED = 3'd5
  } event_t;

  // Classified command passed from the front end to the back end.
  typedef struct packed {
    logic          aging;
    logic          short_pkt;
    logic [31:0]   src_ip;
    logic [31:0]   dst_ip;
    logic [15:0]   src_port;
    logic [15:0]   dst_port;
    logic [15:0]   plen;
    logic [31:0]   now_sec;
    logic [BKT_W-1:0] bkt;
  } job_t;

  // One result item.
  typedef struct packed {
    logic          last;
    logic [15:0]   plen;
    logic [SLOT_W-1:0] slot;
    logic [WAY_W-1:0] way;
    logic [BKT_W-1:0] bkt;
    logic [15:0]   dst_port;
    logic [15:0]   src_port;
    logic [31:0]   dst_ip;
    logic [31:0]   src_ip;
    event_t        ev;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_OUT
  } state_t;
endpackage
`default_nettype wire

### hdl/uft_front.sv
// Front end: accepts input items, hashes and classifies them into a short queue.
`default_nettype none
module uft_front (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic      s_tready,
  input  wire logic [151:0] s_tdata,
  input  wire logic [0:0] s_tuser,
  output uft_pkg::job_t q_job,
  output logic      q_valid,
  input  wire logic q_pop
);
  import uft_pkg::*;

  job_t job_in;
  job_t mem [QUEUE_DEPTH];
  logic wp, rp;
  logic [1:0] cnt;
  logic push;

  // Field unpacking and hashing.
  always_comb begin
    logic [15:0] tot;
    logic [31:0] h;
    tot = s_tdata[111:96];
    h = s_tdata[31:0] ^ s_tdata[63:32] ^ {16'd0, s_tdata[79:64]} ^ {16'd0, s_tdata[95:80]};
    job_in.aging = s_tuser[0];
    job_in.short_pkt = (tot <= HDR_BYTES);
    job_in.src_ip = s_tdata[31:0];
    job_in.dst_ip = s_tdata[63:32];
    job_in.src_port = s_tdata[79:64];
    job_in.dst_port = s_tdata[95:80];
    job_in.plen = (tot <= HDR_BYTES) ? 16'd0 : tot - HDR_BYTES;
    job_in.now_sec = s_tdata[143:112];
    job_in.bkt = s_tuser[0] ? s_tdata[147:144] : h[BKT_W-1:0];
  end

  assign s_tready = (cnt != 2'(QUEUE_DEPTH));
  assign push = s_tvalid && s_tready;
  assign q_valid = (cnt != 2'd0);
  assign q_job = mem[rp];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) mem[wp] <= job_in;
  end

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (q_pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(q_pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    cnt == 2'(QUEUE_DEPTH) |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> cnt != 2'd0) else $error("queue underflow");
  a_count: assert property (@(posedge clk) disable iff (rst)
    push && !q_pop |=> cnt == $past(cnt) + 2'd1) else $error("count slip");
endmodule
`default_nettype wire

### hdl/uft_back.sv
// Back end: bucket read, compare, update and result generation.
`default_nettype none
module uft_back (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic [15:0] timeout_sec,
  input  uft_pkg::job_t q_job,
  input  wire logic q_valid,
  output logic      q_pop,
  output uft_pkg::res_t res,
  output logic      res_valid,
  input  wire logic res_ready,
  output logic      busy
);
  import uft_pkg::*;

  // Way memories: one row per bucket, all ways side by side.
  logic [WAYS*64-1:0] addr_mem [BUCKETS];
  logic [WAYS*32-1:0] port_mem [BUCKETS];
  logic [WAYS*32-1:0] crt_mem [BUCKETS];
  logic [WAYS*CNT_W-1:0] sav_mem [BUCKETS];
  logic [WAYS-1:0] valid [BUCKETS];

  logic [WAYS*64-1:0] rd_addr;
  logic [WAYS*32-1:0] rd_port, rd_crt;
  logic [WAYS*CNT_W-1:0] rd_sav;

  state_t state, state_next;
  job_t job;
  logic [WAYS-1:0] vrow, exp_mask, exp_mask_next;
  logic [WAYS-1:0] hit_vec, exp_vec;
  logic [WAY_W-1:0] way_sel;
  logic load, rd_en;
  logic wr_new, wr_sav, clr_way, exp_pend;
  logic res_load;
  res_t res_next;
  logic [WAY_W-1:0] hit_way, free_way;
  logic hit_any, free_any;

  // Registered row read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_addr <= addr_mem[job.bkt];
      rd_port <= port_mem[job.bkt];
      rd_crt <= crt_mem[job.bkt];
      rd_sav <= sav_mem[job.bkt];
    end
  end

  // Per-way compare.
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w] = vrow[w] && rd_addr[w*64 +: 64] == {job.dst_ip, job.src_ip}
                   && rd_port[w*32 +: 32] == {job.dst_port, job.src_port};
      exp_vec[w] = vrow[w] && ((job.now_sec - rd_crt[w*32 +: 32]) > {16'd0, timeout_sec});
    end
  end

  // Lowest hit and lowest free way.
  always_comb begin
    hit_way = '0;
    free_way = '0;
    hit_any = 1'b0;
    free_any = 1'b0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = WAY_W'(w);
        hit_any = 1'b1;
      end
      if (!vrow[w]) begin
        free_way = WAY_W'(w);
        free_any = 1'b1;
      end
    end
  end

  // Lowest pending expired way and whether more remain.
  always_comb begin
    logic [WAYS-1:0] rest;
    way_sel = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (exp_mask[w]) way_sel = WAY_W'(w);
    end
    rest = exp_mask;
    rest[way_sel] = 1'b0;
    exp_mask_next = rest;
  end
  assign exp_pend = (exp_mask != '0);

  // State register and job capture.
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end
  always_ff @(posedge clk) begin
    if (load) job <= q_job;
  end
  always_ff @(posedge clk) begin
    if (state == ST_READ) vrow <= valid[job.bkt];
    if (state == ST_EVAL) exp_mask <= exp_vec;
    else if (res_load && state == ST_OUT) exp_mask <= exp_mask_next;
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    load = 1'b0;
    rd_en = 1'b0;
    q_pop = 1'b0;
    wr_new = 1'b0;
    wr_sav = 1'b0;
    clr_way = 1'b0;
    res_load = 1'b0;
    res_next = '0;
    res_next.src_ip = job.src_ip;
    res_next.dst_ip = job.dst_ip;
    res_next.src_port = job.src_port;
    res_next.dst_port = job.dst_port;
    res_next.bkt = job.bkt;
    res_next.plen = job.plen;
    res_next.last = 1'b1;
    res_next.ev = EV_IGNORED;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          load = 1'b1;
          q_pop = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        rd_en = 1'b1;
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (job.aging) begin
          state_next = ST_OUT;
        end else if (!res_valid || res_ready) begin
          res_load = 1'b1;
          state_next = ST_IDLE;
          if (job.short_pkt) begin
            res_next.ev = EV_IGNORED;
          end else if (hit_any) begin
            res_next.way = hit_way;
            if (rd_sav[hit_way*CNT_W +: CNT_W] >= SLOTS_FULL) begin
              res_next.ev = EV_FLOW_FULL;
            end else begin
              res_next.ev = EV_SLOT;
              res_next.slot = SLOT_W'(rd_sav[hit_way*CNT_W +: CNT_W]);
              wr_sav = 1'b1;
            end
          end else if (free_any) begin
            res_next.ev = EV_NEW;
            res_next.way = free_way;
            wr_new = 1'b1;
          end else begin
            res_next.ev = EV_BKT_FULL;
          end
        end
      end
      ST_OUT: begin
        if (!exp_pend) begin
          state_next = ST_IDLE;
        end else if (!res_valid || res_ready) begin
          res_load = 1'b1;
          clr_way = 1'b1;
          res_next.ev = EV_EXPIRED;
          res_next.src_ip = rd_addr[way_sel*64 +: 32];
          res_next.dst_ip = rd_addr[way_sel*64 + 32 +: 32];
          res_next.src_port = rd_port[way_sel*32 +: 16];
          res_next.dst_port = rd_port[way_sel*32 + 16 +: 16];
          res_next.way = way_sel;
          res_next.plen = '0;
          res_next.last = (exp_mask_next == '0);
          if (exp_mask_next == '0) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Table updates.
  always_ff @(posedge clk) begin
    if (wr_new) begin
      addr_mem[job.bkt][free_way*64 +: 64] <= {job.dst_ip, job.src_ip};
      port_mem[job.bkt][free_way*32 +: 32] <= {job.dst_port, job.src_port};
      crt_mem[job.bkt][free_way*32 +: 32] <= job.now_sec;
      sav_mem[job.bkt][free_way*CNT_W +: CNT_W] <= '0;
    end else if (wr_sav) begin
      sav_mem[job.bkt][hit_way*CNT_W +: CNT_W] <=
        rd_sav[hit_way*CNT_W +: CNT_W] + CNT_W'(1);
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < BUCKETS; b++) valid[b] <= '0;
    end else if (wr_new) begin
      valid[job.bkt][free_way] <= 1'b1;
    end else if (clr_way) begin
      valid[job.bkt][way_sel] <= 1'b0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) res_valid <= 1'b0;
    else if (res_load) res_valid <= 1'b1;
    else if (res_ready) res_valid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (res_load) res <= res_next;
  end

  assign busy = (state != ST_IDLE) || q_valid || res_valid;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res)) else $error("result changed while stalled");
  a_one_write: assert property (@(posedge clk) disable iff (rst)
    !(wr_new && (wr_sav || clr_way))) else $error("conflicting table writes");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == ST_IDLE) else $error("pop outside idle");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    res_load |-> !res_valid || res_ready) else $error("result overwritten");
endmodule
`default_nettype wire

### hdl/udp_flow_table_with_aging.sv
// Top level of the UDP flow table with timeout aging.
// Channel  Dir  Handshake             Payload
// s_axis   in   s_tvalid/s_tready     tdata item fields and scan_bucket, tuser cmd
// m_axis   out  m_tvalid/m_tready     tdata result fields, tuser event_res, tlast last
// cfg      in   cfg_valid/cfg_ready   timeout_sec, taken only while the block is idle
// A packet passes through the back end as dequeue, bucket row read, then compare and
// write back, set by the single row read-modify-write of the way memories.
// An aging scan reads the bucket row, then emits one result per expired flow, none if none expired.
// A stalled output register holds the back end in its compare or output state.
// Reset clears all way valid bits at once; timeout returns to 15 seconds.
// A two-entry queue lets input be taken while the output register is stalled.
`default_nettype none
module udp_flow_table_with_aging (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic      s_tready,
  // src_ip, dst_ip, src_port, dst_port, ip_total_len, now_sec, scan_bucket, zero fill
  input  wire logic [151:0] s_tdata,
  // cmd
  input  wire logic [0:0] s_tuser,
  output logic      m_tvalid,
  input  wire logic m_tready,
  // flow_src_ip, flow_dst_ip, flow_src_port, flow_dst_port, bucket, way,
  // save_slot, udp_data_len, zero fill
  output logic [127:0] m_tdata,
  // event_res
  output logic [2:0] m_tuser,
  output logic      m_tlast,
  input  wire logic cfg_valid,
  output logic      cfg_ready,
  input  wire logic [15:0] cfg_data
);
  import uft_pkg::*;

  job_t q_job;
  logic q_valid, q_pop, busy;
  res_t res;
  logic [15:0] timeout_sec;

  // Timeout register, written only while no transaction is in flight.
  assign cfg_ready = !busy;
  always_ff @(posedge clk) begin
    if (rst) timeout_sec <= TIMEOUT_RESET;
    else if (cfg_valid && cfg_ready) timeout_sec <= cfg_data;
  end

  uft_front u_front (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata), .s_tuser(s_tuser),
    .q_job(q_job), .q_valid(q_valid), .q_pop(q_pop)
  );

  uft_back u_back (
    .clk(clk), .rst(rst), .timeout_sec(timeout_sec), .q_job(q_job),
    .q_valid(q_valid), .q_pop(q_pop), .res(res), .res_valid(m_tvalid),
    .res_ready(m_tready), .busy(busy)
  );

  // Output packing.
  assign m_tdata = {7'd0, res.plen, res.slot, res.way, res.bkt, res.dst_port,
                    res.src_port, res.dst_ip, res.src_ip};
  assign m_tuser = res.ev;
  assign m_tlast = res.last;

  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    busy |=> $stable(timeout_sec)) else $error("timeout changed while busy");
endmodule
`default_nettype wire
